// ===== src/bost_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bost_pkg
// Shared types for the bounded ordered set table: request kinds, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bost_pkg;

  // Request kinds carried on the input tuser field
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // Width of the capacity register and of the count field
  localparam int CAP_W   = 5;
  localparam int VALUE_W = 32;

  // Controller -> datapath
  typedef struct packed {
    logic load;           // latch a new request, restart the sweep
    logic scan_step;      // issue the next search read
    logic shift_start;    // begin shift-down after the hit slot
    logic shift_step;     // issue next shift read, write back previous one
    logic commit_insert;  // append value, bump count
    logic commit_remove;  // drop count by one
    logic ok_set;         // capture result flag
    logic ok_val;
    logic out_load;       // move result into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    req_kind_t kind;
    logic      hit;         // compared entry matches the request value
    logic      sweep_done;  // nothing left to read, nothing in flight
    logic      room;        // count below the active limit
  } sts_t;

endpackage

// ===== src/bost_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bost_ctrl
// Request sequencer: accept, search sweep, optional shift-down, result
// hand-off into the output register.
// ----------------------------------------------------------------------------
module bost_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  bost_pkg::sts_t  sts,
  output bost_pkg::cmd_t  cmd
);
  import bost_pkg::*;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        cmd.scan_step = 1'b1;
        if (sts.hit && sts.kind == REQ_REMOVE) begin
          cmd.shift_start = 1'b1;
          state_nxt       = ST_SHIFT;
        end else if (sts.hit || sts.sweep_done) begin
          cmd.ok_set = 1'b1;
          priority case (sts.kind)
            REQ_INSERT: begin
              cmd.ok_val        = !sts.hit && sts.room;
              cmd.commit_insert = !sts.hit && sts.room;
            end
            REQ_QUERY: cmd.ok_val = sts.hit;
            default:   cmd.ok_val = 1'b0;
          endcase
          state_nxt = ST_DONE;
        end
      end

      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.sweep_done) begin
          cmd.commit_remove = 1'b1;
          cmd.ok_set        = 1'b1;
          cmd.ok_val        = 1'b1;
          state_nxt         = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared once taken
  always_comb begin
    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ===== src/bost_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bost_dp
// Entry memory, sweep counter with registered read, comparator, count and
// capacity registers, output register.
// ----------------------------------------------------------------------------
module bost_dp #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_tuser,
  input  logic [31:0]     in_tdata,
  input  logic            cfg_wr_en,
  input  logic [4:0]      cfg_wr_data,
  output logic [7:0]      out_tdata,
  input  bost_pkg::cmd_t  cmd,
  output bost_pkg::sts_t  sts
);
  import bost_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  logic [VALUE_W-1:0] mem [DEPTH];

  req_kind_t          kind_r;
  logic [VALUE_W-1:0] value_r;
  logic [CW-1:0]      scan_r, scan_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [VALUE_W-1:0] rd_data_r;
  logic [CW-1:0]      held_r;
  logic [CAP_W-1:0]   cap_r;
  logic               ok_r;
  logic               out_ok_r;
  logic [CAP_W-1:0]   out_count_r;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [LW-1:0]      held_ext;
  logic [LW-1:0]      cap_ext;

  assign held_ext = LW'(held_r);
  assign cap_ext  = LW'(cap_r);

  // Sweep counter: next read address and in-flight tracking
  always_comb begin
    scan_nxt   = scan_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    if (cmd.load) begin
      scan_nxt = '0;
    end else if (cmd.shift_start) begin
      scan_nxt = CW'(rd_idx_r) + CW'(1);
    end else if ((cmd.scan_step || cmd.shift_step) && scan_r < held_r) begin
      scan_nxt   = scan_r + CW'(1);
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = scan_r[IW-1:0];
    end
  end

  // Memory write: append on insert, move entry down one slot on shift
  always_comb begin
    mem_we    = cmd.commit_insert || (cmd.shift_step && rd_vld_r);
    mem_waddr = cmd.commit_insert ? held_r[IW-1:0] : rd_idx_r - IW'(1);
    mem_wdata = cmd.commit_insert ? value_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_r[IW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      held_r   <= '0;
      cap_r    <= CAP_W'(16);
    end else begin
      rd_vld_r <= rd_vld_nxt;
      if (cmd.commit_insert) begin
        held_r <= held_r + CW'(1);
      end else if (cmd.commit_remove) begin
        held_r <= held_r - CW'(1);
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // Request, sweep and result payload
  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (cmd.load) begin
      kind_r  <= req_kind_t'(in_tuser);
      value_r <= in_tdata;
    end
    if (cmd.ok_set) begin
      ok_r <= cmd.ok_val;
    end
    if (cmd.out_load) begin
      out_ok_r    <= ok_r;
      out_count_r <= held_ext[CAP_W-1:0];
    end
  end

  // Status back to the controller
  always_comb begin
    sts.kind       = kind_r;
    sts.hit        = rd_vld_r && (rd_data_r == value_r);
    sts.sweep_done = !rd_vld_r && (scan_r >= held_r);
    sts.room       = (held_ext < cap_ext) && (held_r < CW'(DEPTH));
  end

  assign out_tdata = {2'b00, out_count_r, out_ok_r};

endmodule

// ===== src/bounded_ordered_set_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_ordered_set_table_core
// Set of distinct 32-bit values kept packed in insertion order with a count.
//
// Input stream: in_tuser carries the request kind (insert, remove, query),
// in_tdata the value. One request is handled at a time; in_tready is high
// only while the block is idle. Output stream: one result per request with
// the success flag and the count after the request.
// Search: a search reads one entry per cycle through the single memory
// read port and stops at the first match, after which insert and query
// load the result register. A remove that hits moves every later entry
// down one slot, one per cycle, and then loads its result. After a result
// is loaded, the block returns to idle before it accepts the next request.
// The output register holds a result until taken; the next request is
// accepted meanwhile, but its result waits in the done state while the
// receiver stalls.
// Reset clears the count and sets capacity to 16; entries are not cleared.
// cfg_wr_en writes the capacity; the limit in force is min(capacity, DEPTH).
// ----------------------------------------------------------------------------
module bounded_ordered_set_table_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] ok, [5:1] count, [7:6] zero
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  import bost_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bost_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bost_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

  // One request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one still in work");

  // Append only when the set has room and the value is absent
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_insert |-> (sts.room && !sts.hit))
    else $error("insert committed without room or on duplicate");

  // Count never moves both ways at once
  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit_insert && cmd.commit_remove))
    else $error("insert and remove committed together");

  // A new result only appears after the controller loads it
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.out_load))
    else $error("output valid raised without a result load");

endmodule
